// ----- hdl/assert_macros.svh -----
// Assertion helpers used by the controller RTL.
// Each macro builds one labeled concurrent assertion, clocked on the rising
// edge and disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error(msg);

`endif

// ----- hdl/csmatx_pkg.sv -----
// ----------------------------------------------------------------------------
// csmatx_pkg
// Shared widths, codes and reset values for the airtime-limited CSMA
// transmit controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package csmatx_pkg;

  // Width of timestamps and airtime accumulators.
  localparam int TIME_W = 32;

  // Event codes on the operation field.
  localparam logic [2:0] OP_TICK    = 3'd0;
  localparam logic [2:0] OP_SEND    = 3'd1;
  localparam logic [2:0] OP_CCA     = 3'd2;
  localparam logic [2:0] OP_TX_DONE = 3'd3;
  localparam logic [2:0] OP_TIMEOUT = 3'd4;

  // Radio action codes.
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_CCA   = 3'd1;
  localparam logic [2:0] ACT_TX    = 3'd2;
  localparam logic [2:0] ACT_RX    = 3'd3;
  localparam logic [2:0] ACT_RESET = 3'd4;

  // Send confirm status codes.
  localparam logic [1:0] CONF_SUCCESS = 2'd0;
  localparam logic [1:0] CONF_BUSY    = 2'd1;
  localparam logic [1:0] CONF_NO_ACK  = 2'd2;
  localparam logic [1:0] CONF_LIMITED = 2'd3;

  // Register indexes (byte address divided by four).
  localparam logic [2:0] REG_PERMIT   = 3'd0;
  localparam logic [2:0] REG_WINDOW   = 3'd1;
  localparam logic [2:0] REG_INTERVAL = 3'd2;
  localparam logic [2:0] REG_OVERHEAD = 3'd3;
  localparam logic [2:0] REG_MAX_LEN  = 3'd4;
  localparam logic [2:0] REG_PAD      = 3'd5;

  // Register reset values: one hour plus three minutes window, 350 s permit.
  localparam logic [TIME_W-1:0] PERMIT_RST   = TIME_W'(360000 - 10000);
  localparam logic [TIME_W-1:0] WINDOW_RST   = TIME_W'(3600000 + 180000);
  localparam logic [15:0]       INTERVAL_RST = 16'd50;
  localparam logic [7:0]        OVERHEAD_RST = 8'd10;
  localparam logic [7:0]        MAX_LEN_RST  = 8'd30;
  localparam logic [7:0]        PAD_RST      = 8'd30;

endpackage

`default_nettype wire

// ----- hdl/csma_tx_controller_duty_limit.sv -----
// ----------------------------------------------------------------------------
// csma_tx_controller_duty_limit
// CSMA transmit controller with a cumulative airtime limit per window.
// Each event beat yields one result beat telling the radio what to do.
// ----------------------------------------------------------------------------
//  Channel  | Handshake                   | Payload
//  ---------+-----------------------------+-------------------------------------
//  cmd      | cmd_valid / cmd_ready       | operation, now_ms, payload_len,
//           |                             | cca_status
//  res      | res_valid / res_ready       | radio_action, pad_bytes,
//           |                             | confirm_valid, confirm_status,
//           |                             | dropped, send_limited
//  apb      | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
//  One event is accepted per cycle while no result is stalled; its result
//  appears in the next cycle, from the single result register behind the event logic.
//  cmd_ready is high while the result register is empty or being drained,
//  so a stalled result holds off new events without losing one.
//  Synchronous reset returns the controller to idle with zero airtime and
//  the registers at their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module csma_tx_controller_duty_limit (
  input  wire logic        clk,
  input  wire logic        rst,
  // Event channel
  input  wire logic        cmd_valid,
  output logic             cmd_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] now_ms,
  input  wire logic [7:0]  payload_len,
  input  wire logic [1:0]  cca_status,
  // Result channel
  output logic             res_valid,
  input  wire logic        res_ready,
  output logic [2:0]       radio_action,
  output logic [7:0]       pad_bytes,
  output logic             confirm_valid,
  output logic [1:0]       confirm_status,
  output logic             dropped,
  output logic             send_limited,
  // Configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int TW = csmatx_pkg::TIME_W;

  // Controller phase codes.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CCA  = 2'd1;
  localparam logic [1:0] PH_TX   = 2'd2;

  // Configuration registers.
  logic [TW-1:0] permit_time;
  logic [TW-1:0] window_period;
  logic [15:0]   check_interval;
  logic [7:0]    tx_overhead;
  logic [7:0]    max_payload;
  logic [7:0]    pad_target;

  // Controller state.
  logic [1:0]    phase;
  logic [1:0]    phase_next;
  logic          limit_active;
  logic          limit_active_next;
  logic [TW-1:0] tx_start_time;
  logic [TW-1:0] tx_start_time_next;
  logic [TW-1:0] airtime_total;
  logic [TW-1:0] airtime_total_next;
  logic [TW-1:0] window_start;
  logic [TW-1:0] window_start_next;
  logic [TW-1:0] last_check;
  logic [TW-1:0] last_check_next;
  logic [7:0]    held_length;
  logic [7:0]    held_length_next;

  // Result fields before the output register.
  logic [2:0]    action_next;
  logic [7:0]    pad_next;
  logic          cvalid_next;
  logic [1:0]    cstat_next;
  logic          drop_next;

  // Intermediate arithmetic.
  logic          cmd_fire;
  logic          cfg_write;
  logic [2:0]    reg_index;
  logic [TW-1:0] since_check;
  logic [TW-1:0] since_window;
  logic [TW-1:0] tx_elapsed;
  logic [TW+1:0] airtime_sum;
  logic [TW-1:0] airtime_sat;

  assign cmd_ready = !res_valid || res_ready;
  assign cmd_fire  = cmd_valid && cmd_ready;
  assign pready    = 1'b1;
  assign reg_index = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      permit_time    <= csmatx_pkg::PERMIT_RST;
      window_period  <= csmatx_pkg::WINDOW_RST;
      check_interval <= csmatx_pkg::INTERVAL_RST;
      tx_overhead    <= csmatx_pkg::OVERHEAD_RST;
      max_payload    <= csmatx_pkg::MAX_LEN_RST;
      pad_target     <= csmatx_pkg::PAD_RST;
    end else if (cfg_write) begin
      unique case (reg_index)
        csmatx_pkg::REG_PERMIT:   permit_time    <= pwdata[TW-1:0];
        csmatx_pkg::REG_WINDOW:   window_period  <= pwdata[TW-1:0];
        csmatx_pkg::REG_INTERVAL: check_interval <= pwdata[15:0];
        csmatx_pkg::REG_OVERHEAD: tx_overhead    <= pwdata[7:0];
        csmatx_pkg::REG_MAX_LEN:  max_payload    <= pwdata[7:0];
        csmatx_pkg::REG_PAD:      pad_target     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    unique case (reg_index)
      csmatx_pkg::REG_PERMIT:   prdata = permit_time;
      csmatx_pkg::REG_WINDOW:   prdata = window_period;
      csmatx_pkg::REG_INTERVAL: prdata = {16'd0, check_interval};
      csmatx_pkg::REG_OVERHEAD: prdata = {24'd0, tx_overhead};
      csmatx_pkg::REG_MAX_LEN:  prdata = {24'd0, max_payload};
      csmatx_pkg::REG_PAD:      prdata = {24'd0, pad_target};
      default:                  prdata = 32'd0;
    endcase
  end

  // Elapsed times wrap modulo the timestamp width.
  assign since_check  = now_ms - last_check;
  assign since_window = now_ms - window_start;
  assign tx_elapsed   = now_ms - tx_start_time;

  // Total plus elapsed plus overhead in one add; saturating once is the same
  // as saturating after each of the two additions.
  assign airtime_sum = {2'b00, airtime_total} + {2'b00, tx_elapsed}
                     + {{(TW-6){1'b0}}, tx_overhead};
  assign airtime_sat = (airtime_sum[TW+1:TW] != 2'b00) ? {TW{1'b1}} : airtime_sum[TW-1:0];

  // Event handling for one beat.
  always_comb begin
    phase_next         = phase;
    limit_active_next  = limit_active;
    tx_start_time_next = tx_start_time;
    airtime_total_next = airtime_total;
    window_start_next  = window_start;
    last_check_next    = last_check;
    held_length_next   = held_length;
    action_next        = csmatx_pkg::ACT_NONE;
    pad_next           = 8'd0;
    cvalid_next        = 1'b0;
    cstat_next         = csmatx_pkg::CONF_SUCCESS;
    drop_next          = 1'b0;

    unique case (operation)
      csmatx_pkg::OP_TICK: begin
        // Window expiry is checked at most once per check interval.
        if (since_check >= {{(TW-16){1'b0}}, check_interval}) begin
          last_check_next = now_ms;
          if (since_window > window_period) begin
            window_start_next  = now_ms;
            airtime_total_next = '0;
            limit_active_next  = 1'b0;
          end
        end
      end
      csmatx_pkg::OP_SEND: begin
        // Busy beats are dropped; the limit is checked before the length.
        priority if (phase != PH_IDLE) begin
          drop_next = 1'b1;
        end else if (limit_active) begin
          cvalid_next = 1'b1;
          cstat_next  = csmatx_pkg::CONF_LIMITED;
        end else if (payload_len > max_payload) begin
          drop_next = 1'b1;
        end else begin
          held_length_next = payload_len;
          phase_next       = PH_CCA;
          action_next      = csmatx_pkg::ACT_CCA;
        end
      end
      csmatx_pkg::OP_CCA: begin
        if (phase == PH_CCA) begin
          if (cca_status == 2'd0) begin
            tx_start_time_next = now_ms;
            phase_next         = PH_TX;
            action_next        = csmatx_pkg::ACT_TX;
            pad_next = (held_length < pad_target) ? (pad_target - held_length) : 8'd0;
          end else begin
            phase_next  = PH_IDLE;
            action_next = csmatx_pkg::ACT_RX;
            cvalid_next = 1'b1;
            cstat_next  = csmatx_pkg::CONF_BUSY;
          end
        end
      end
      csmatx_pkg::OP_TX_DONE: begin
        if (phase == PH_TX) begin
          airtime_total_next = airtime_sat;
          if (airtime_sat > permit_time) begin
            limit_active_next = 1'b1;
          end
          phase_next  = PH_IDLE;
          action_next = csmatx_pkg::ACT_RX;
          cvalid_next = 1'b1;
          cstat_next  = csmatx_pkg::CONF_SUCCESS;
        end
      end
      csmatx_pkg::OP_TIMEOUT: begin
        if (phase != PH_IDLE) begin
          phase_next  = PH_IDLE;
          action_next = csmatx_pkg::ACT_RESET;
          cvalid_next = 1'b1;
          cstat_next  = csmatx_pkg::CONF_NO_ACK;
        end
      end
      default: ;
    endcase
  end

  // Control state updates on each accepted beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      limit_active  <= 1'b0;
      tx_start_time <= '0;
      airtime_total <= '0;
      window_start  <= '0;
      last_check    <= '0;
      held_length   <= 8'd0;
    end else if (cmd_fire) begin
      phase         <= phase_next;
      limit_active  <= limit_active_next;
      tx_start_time <= tx_start_time_next;
      airtime_total <= airtime_total_next;
      window_start  <= window_start_next;
      last_check    <= last_check_next;
      held_length   <= held_length_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd_fire) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      radio_action   <= action_next;
      pad_bytes      <= pad_next;
      confirm_valid  <= cvalid_next;
      confirm_status <= cstat_next;
      dropped        <= drop_next;
      send_limited   <= limit_active_next;
    end
  end

  // Checks on the controller's own behavior.
  `ASSERT_NEXT(a_busy_send_dropped, clk, rst, cmd_fire && (operation == csmatx_pkg::OP_SEND) && (phase != PH_IDLE), res_valid && dropped && (radio_action == csmatx_pkg::ACT_NONE), "send beat while busy was not dropped")
  `ASSERT_SAME(a_tx_phase, clk, rst, res_valid && (radio_action == csmatx_pkg::ACT_TX), phase == PH_TX, "start transmit shown without transmit phase")
  `ASSERT_SAME(a_limit_clear, clk, rst, $fell(limit_active), $past(rst) || $past(cmd_fire && (operation == csmatx_pkg::OP_TICK)), "airtime limit cleared outside a tick")

endmodule

`default_nettype wire

// ----- dv/csmatx_checker.sv -----
// ----------------------------------------------------------------------------
// csmatx_checker
// Watches the event, result and register channels of the airtime-limited
// CSMA transmit controller. It keeps its own copy of the controller state
// and registers, works out the reply to every accepted event beat, and
// compares each accepted result beat field by field with the oldest reply
// still owed.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module csmatx_checker
  import csmatx_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cmd_valid,
  input  wire logic        cmd_ready,
  input  wire logic [2:0]  operation,
  input  wire logic [31:0] now_ms,
  input  wire logic [7:0]  payload_len,
  input  wire logic [1:0]  cca_status,
  input  wire logic        res_valid,
  input  wire logic        res_ready,
  input  wire logic [2:0]  radio_action,
  input  wire logic [7:0]  pad_bytes,
  input  wire logic        confirm_valid,
  input  wire logic [1:0]  confirm_status,
  input  wire logic        dropped,
  input  wire logic        send_limited,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  output int               fail_count,
  output int               pending
);

  typedef enum logic [1:0] {
    CTL_IDLE,
    CTL_WAIT_CCA,
    CTL_WAIT_TX
  } ctl_phase_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] pad;
    logic       cvalid;
    logic [1:0] cstat;
    logic       drop;
    logic       limited;
  } reply_t;

  // Register copy.
  logic [TIME_W-1:0] permit_r;
  logic [TIME_W-1:0] window_r;
  logic [15:0]       interval_r;
  logic [7:0]        overhead_r;
  logic [7:0]        max_len_r;
  logic [7:0]        pad_r;

  // Controller state copy.
  ctl_phase_t        ctl_phase;
  logic              limit_on;
  logic [TIME_W-1:0] tx_start;
  logic [TIME_W-1:0] airtime;
  logic [TIME_W-1:0] win_start;
  logic [TIME_W-1:0] last_check;
  logic [7:0]        held_len;

  reply_t reply_q[$];
  reply_t oldest;
  int     fail_tally = 0;

  assign fail_count = fail_tally;

  // Add two airtime values, sticking at all ones on overflow.
  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[TIME_W] ? '1 : sum[TIME_W-1:0];
  endfunction

  // Advance the state copy by one event and return the reply it owes.
  function automatic reply_t predict_reply(input logic [2:0]        op,
                                           input logic [TIME_W-1:0] now,
                                           input logic [7:0]        len,
                                           input logic [1:0]        cca);
    reply_t            r;
    logic [TIME_W-1:0] since;
    r = '0;
    case (op)
      OP_TICK: begin
        since = now - last_check;
        if (since >= TIME_W'(interval_r)) begin
          last_check = now;
          since = now - win_start;
          if (since > window_r) begin
            win_start = now;
            airtime   = '0;
            limit_on  = 1'b0;
          end
        end
      end
      OP_SEND: begin
        // A busy controller drops first, then the limit refuses, then length.
        if (ctl_phase != CTL_IDLE) begin
          r.drop = 1'b1;
        end else if (limit_on) begin
          r.cvalid = 1'b1;
          r.cstat  = CONF_LIMITED;
        end else if (len > max_len_r) begin
          r.drop = 1'b1;
        end else begin
          held_len  = len;
          ctl_phase = CTL_WAIT_CCA;
          r.action  = ACT_CCA;
        end
      end
      OP_CCA: begin
        if (ctl_phase == CTL_WAIT_CCA) begin
          if (cca == 2'b00) begin
            tx_start  = now;
            ctl_phase = CTL_WAIT_TX;
            r.action  = ACT_TX;
            r.pad     = (held_len < pad_r) ? pad_r - held_len : 8'd0;
          end else begin
            ctl_phase = CTL_IDLE;
            r.action  = ACT_RX;
            r.cvalid  = 1'b1;
            r.cstat   = CONF_BUSY;
          end
        end
      end
      OP_TX_DONE: begin
        if (ctl_phase == CTL_WAIT_TX) begin
          since   = now - tx_start;
          airtime = add_sat(airtime, since);
          airtime = add_sat(airtime, TIME_W'(overhead_r));
          if (airtime > permit_r) limit_on = 1'b1;
          ctl_phase = CTL_IDLE;
          r.action  = ACT_RX;
          r.cvalid  = 1'b1;
          r.cstat   = CONF_SUCCESS;
        end
      end
      OP_TIMEOUT: begin
        if (ctl_phase != CTL_IDLE) begin
          ctl_phase = CTL_IDLE;
          r.action  = ACT_RESET;
          r.cvalid  = 1'b1;
          r.cstat   = CONF_NO_ACK;
        end
      end
      default: begin
      end
    endcase
    r.limited = limit_on;
    return r;
  endfunction

  // Report one field that differs from its expected value.
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      fail_tally++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // Register writes, result comparison and event prediction, in that order.
  always @(posedge clk) begin
    if (rst) begin
      permit_r   = PERMIT_RST;
      window_r   = WINDOW_RST;
      interval_r = INTERVAL_RST;
      overhead_r = OVERHEAD_RST;
      max_len_r  = MAX_LEN_RST;
      pad_r      = PAD_RST;
      ctl_phase  = CTL_IDLE;
      limit_on   = 1'b0;
      tx_start   = '0;
      airtime    = '0;
      win_start  = '0;
      last_check = '0;
      held_len   = '0;
      reply_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_PERMIT:   permit_r   = pwdata;
          REG_WINDOW:   window_r   = pwdata;
          REG_INTERVAL: interval_r = pwdata[15:0];
          REG_OVERHEAD: overhead_r = pwdata[7:0];
          REG_MAX_LEN:  max_len_r  = pwdata[7:0];
          REG_PAD:      pad_r      = pwdata[7:0];
          default: begin
          end
        endcase
      end
      if (res_valid && res_ready) begin
        if (reply_q.size() == 0) begin
          fail_tally++;
          $display("%0t: result beat with no event outstanding, expected none, actual %h",
                   $time, {radio_action, pad_bytes, confirm_valid, confirm_status,
                           dropped, send_limited});
        end else begin
          oldest = reply_q.pop_front();
          check_field("radio_action", 32'(oldest.action), 32'(radio_action));
          check_field("pad_bytes", 32'(oldest.pad), 32'(pad_bytes));
          check_field("confirm_valid", 32'(oldest.cvalid), 32'(confirm_valid));
          check_field("confirm_status", 32'(oldest.cstat), 32'(confirm_status));
          check_field("dropped", 32'(oldest.drop), 32'(dropped));
          check_field("send_limited", 32'(oldest.limited), 32'(send_limited));
        end
      end
      if (cmd_valid && cmd_ready) begin
        reply_q.push_back(predict_reply(operation, now_ms, payload_len, cca_status));
      end
    end
    pending <= reply_q.size();
  end

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the airtime-limited CSMA transmit controller.
// A directed pass covers stray events, drops, refusals, padding, the limit
// and the window reopening; random send, assess and transmit sequences with
// noise then run under several register settings, the extremes among them.
// Both channels idle at random; a separate checker judges every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import csmatx_pkg::*;

  localparam logic [1:0] CCA_CLEAR = 2'b00;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        cmd_valid   = 1'b0;
  logic [2:0]  operation   = '0;
  logic [31:0] now_ms      = '0;
  logic [7:0]  payload_len = '0;
  logic [1:0]  cca_status  = '0;
  logic        res_ready   = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [4:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;

  wire logic        cmd_ready;
  wire logic        res_valid;
  wire logic [2:0]  radio_action;
  wire logic [7:0]  pad_bytes;
  wire logic        confirm_valid;
  wire logic [1:0]  confirm_status;
  wire logic        dropped;
  wire logic        send_limited;
  wire logic [31:0] prdata;
  wire logic        pready;

  int fail_count;
  int pending;

  // Shared by both sides: when set, neither side idles.
  logic        steady      = 1'b0;
  int unsigned events_sent = 0;
  logic [31:0] stamp_ms    = '0;
  logic [7:0]  cfg_max_len = MAX_LEN_RST;

  always #2 clk = ~clk;

  csma_tx_controller_duty_limit u_top (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .operation      (operation),
    .now_ms         (now_ms),
    .payload_len    (payload_len),
    .cca_status     (cca_status),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .radio_action   (radio_action),
    .pad_bytes      (pad_bytes),
    .confirm_valid  (confirm_valid),
    .confirm_status (confirm_status),
    .dropped        (dropped),
    .send_limited   (send_limited),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  csmatx_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (cmd_valid),
    .cmd_ready      (cmd_ready),
    .operation      (operation),
    .now_ms         (now_ms),
    .payload_len    (payload_len),
    .cca_status     (cca_status),
    .res_valid      (res_valid),
    .res_ready      (res_ready),
    .radio_action   (radio_action),
    .pad_bytes      (pad_bytes),
    .confirm_valid  (confirm_valid),
    .confirm_status (confirm_status),
    .dropped        (dropped),
    .send_limited   (send_limited),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .pready         (pready),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  // Present one event beat, hold it until accepted, then maybe idle.
  task automatic send_event(input logic [2:0] op, input logic [31:0] stamp,
                            input logic [7:0] len, input logic [1:0] cca);
    int unsigned gap;
    cmd_valid   <= 1'b1;
    operation   <= op;
    now_ms      <= stamp;
    payload_len <= len;
    cca_status  <= cca;
    do @(posedge clk); while (!cmd_ready);
    events_sent++;
    if ($urandom_range(0, 59) == 0) steady = ~steady;
    gap = steady ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // One register write: setup cycle, then access until pready.
  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Stop sending and wait until every owed result beat has arrived.
  task automatic drain_results();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all six registers; unused upper bits carry random junk.
  task automatic apply_settings(input logic [31:0] permit, input logic [31:0] window,
                                input logic [15:0] interval, input logic [7:0] overhead,
                                input logic [7:0] max_len, input logic [7:0] pad);
    write_reg(REG_PERMIT, permit);
    write_reg(REG_WINDOW, window);
    write_reg(REG_INTERVAL, {16'($urandom), interval});
    write_reg(REG_OVERHEAD, {24'($urandom), overhead});
    write_reg(REG_MAX_LEN, {24'($urandom), max_len});
    write_reg(REG_PAD, {24'($urandom), pad});
    cfg_max_len = max_len;
  endtask

  // Move the timestamp forward, now and then by a wild jump.
  task automatic advance(input int unsigned span);
    if ($urandom_range(0, 49) == 0) stamp_ms += $urandom();
    else stamp_ms += $urandom_range(0, span);
  endtask

  // Mostly lengths that fit, sometimes any length.
  function automatic logic [7:0] pick_len();
    if ($urandom_range(0, 3) == 0) return 8'($urandom);
    return 8'($urandom_range(0, cfg_max_len));
  endfunction

  // Directed events with the registers at their reset values.
  task automatic directed_defaults();
    // Stray and unknown events from idle.
    send_event(OP_TICK, 32'd0, 8'hFF, 2'b11);
    send_event(OP_TIMEOUT, 32'd5, 8'h00, 2'b00);
    send_event(OP_CCA, 32'd6, 8'h00, CCA_CLEAR);
    send_event(OP_TX_DONE, 32'd7, 8'h00, 2'b00);
    send_event(3'd5, 32'd8, 8'h55, 2'b01);
    send_event(3'd6, 32'd9, 8'hAA, 2'b10);
    send_event(3'd7, 32'hFFFF_FFFF, 8'hFF, 2'b11);
    // A full exchange with sends dropped while busy.
    send_event(OP_SEND, 32'd100, 8'd0, 2'b00);
    send_event(OP_SEND, 32'd101, 8'd5, 2'b00);
    send_event(OP_CCA, 32'd200, 8'd0, CCA_CLEAR);
    send_event(OP_SEND, 32'd250, 8'd5, 2'b00);
    send_event(OP_TX_DONE, 32'd300, 8'd0, 2'b00);
    // Length just over the limit, then a busy channel.
    send_event(OP_SEND, 32'd400, 8'd31, 2'b00);
    send_event(OP_SEND, 32'd410, 8'd30, 2'b00);
    send_event(OP_CCA, 32'd420, 8'd0, 2'b11);
    send_event(OP_SEND, 32'd430, 8'd255, 2'b00);
    // Timeout while waiting for the channel.
    send_event(OP_SEND, 32'd500, 8'd12, 2'b00);
    send_event(OP_TIMEOUT, 32'd600, 8'd0, 2'b00);
    // A long transmission trips the limit; the limit wins over the length.
    send_event(OP_SEND, 32'd1000, 8'd30, 2'b00);
    send_event(OP_CCA, 32'd1000, 8'd0, CCA_CLEAR);
    send_event(OP_TX_DONE, 32'd401000, 8'd0, 2'b00);
    send_event(OP_SEND, 32'd401010, 8'd255, 2'b00);
    // The window expires on a tick, then a tick comes too soon to check.
    send_event(OP_TICK, 32'd3780001, 8'd0, 2'b00);
    send_event(OP_TICK, 32'd3780020, 8'd0, 2'b00);
    stamp_ms = 32'd3780020;
  endtask

  // With every register at its maximum, drive the airtime total into saturation.
  task automatic directed_saturation();
    send_event(OP_TIMEOUT, stamp_ms, 8'd0, 2'b00);
    send_event(OP_SEND, stamp_ms, 8'd0, 2'b00);
    send_event(OP_CCA, stamp_ms, 8'd0, CCA_CLEAR);
    send_event(OP_TX_DONE, stamp_ms - 32'd1, 8'd0, 2'b00);
    send_event(OP_SEND, stamp_ms, 8'd255, 2'b00);
    send_event(OP_CCA, stamp_ms, 8'd0, CCA_CLEAR);
    send_event(OP_TX_DONE, stamp_ms + 32'hFFFF_FFF0, 8'd0, 2'b00);
  endtask

  // Clear a pending exchange and reopen the window, given a zero interval and period.
  task automatic reopen_window();
    send_event(OP_TIMEOUT, stamp_ms, 8'($urandom), 2'($urandom));
    stamp_ms += 32'd1;
    send_event(OP_TICK, stamp_ms, 8'($urandom), 2'($urandom));
  endtask

  // Random traffic: mostly well-formed exchanges, plus ticks and noise.
  task automatic run_traffic(input int unsigned count, input int unsigned span,
                             input int unsigned tx_span);
    int unsigned stop_at;
    int unsigned pick;
    logic [1:0]  cca;
    stop_at = events_sent + count;
    while (events_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if ($urandom_range(0, 2) == 0) begin
          advance(span);
          send_event(OP_TICK, stamp_ms, 8'($urandom), 2'($urandom));
        end
        advance(span);
        send_event(OP_SEND, stamp_ms, pick_len(), 2'($urandom));
        advance(span / 8);
        cca = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(1, 3)) : CCA_CLEAR;
        send_event(OP_CCA, stamp_ms, 8'($urandom), cca);
        if ($urandom_range(0, 9) == 0) begin
          advance(span);
          send_event(OP_TIMEOUT, stamp_ms, 8'($urandom), 2'($urandom));
        end else begin
          stamp_ms += $urandom_range(0, tx_span);
          send_event(OP_TX_DONE, stamp_ms, 8'($urandom), 2'($urandom));
        end
      end else if (pick < 85) begin
        advance(span);
        send_event(OP_TICK, stamp_ms, 8'($urandom), 2'($urandom));
      end else begin
        advance(span);
        send_event(3'($urandom_range(0, 7)), stamp_ms, 8'($urandom), 2'($urandom));
      end
    end
  endtask

  // Result side: stall a random number of cycles before each beat.
  initial begin : result_sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 11);
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!(res_valid && res_ready));
    end
  end

  // Main sequence of phases and the verdict.
  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed_defaults();
    run_traffic(200, 20000, 60000);

    // Every register at zero.
    drain_results();
    apply_settings('0, '0, '0, '0, '0, '0);
    run_traffic(150, 50, 50);
    reopen_window();

    // Every register at its maximum.
    drain_results();
    apply_settings('1, '1, '1, '1, '1, '1);
    directed_saturation();
    run_traffic(150, 1 << 24, 32'hFFFF_FFFF);

    // Random moderate settings.
    repeat (4) begin
      drain_results();
      apply_settings($urandom_range(0, 20000), $urandom_range(0, 100000),
                     16'($urandom_range(0, 300)), 8'($urandom), 8'($urandom),
                     8'($urandom));
      run_traffic(150, 2000, 3000);
    end

    // Back to the reset values, written explicitly.
    drain_results();
    apply_settings(PERMIT_RST, WINDOW_RST, INTERVAL_RST, OVERHEAD_RST, MAX_LEN_RST,
                   PAD_RST);
    run_traffic(100, 20000, 60000);

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule
